// ----- hw/rtl/btsp_pkg.sv -----
package btsp_pkg;

  localparam int POSITION_BITS_DEF     = 16;
  localparam int MAX_LEN_OCTETS_DEF    = 4;
  localparam int VALUE_BITS_DEF        = 64;

  localparam int VALUE_W     = 64;
  localparam int NB_W        = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0]  TAG_HIGH_NUM  = 5'h1f;
  localparam logic [31:0] LEN_SAT_LIMIT = 32'h00ff_ffff;
  localparam logic [31:0] LEN_SAT       = 32'hffff_ffff;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_LEN,
    PH_LENX,
    PH_VALUE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MULTI_TAG = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_PAST_END  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_buffer;
    logic [15:0] buffer_length;
  } in_t;

  typedef struct packed {
    logic [7:0]          tag_byte;
    logic [15:0]         value_length;
    logic [15:0]         value_offset;
    logic signed [63:0]  signed_value;
    logic [63:0]         unsigned_value;
    logic [2:0]          parse_status;
    logic                buffer_done;
  } out_t;

  // finished element as handed from front to back
  typedef struct packed {
    logic [7:0]         tag;
    logic [15:0]        length;
    logic [15:0]        offset;
    logic [VALUE_W-1:0] raw;
    logic [NB_W-1:0]    nbytes;
    status_t            status;
    logic               done;
  } ev_t;

endpackage

// ----- hw/rtl/btsp_front.sv -----
module btsp_front
  import btsp_pkg::*;
#(
  parameter int POSITION_BITS     = POSITION_BITS_DEF,
  parameter int MAX_LENGTH_OCTETS = MAX_LEN_OCTETS_DEF,
  parameter int VALUE_BITS        = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  in_t  in_item,
  output logic ev_valid,
  output ev_t  ev
);

  localparam int LOS_W = $clog2(MAX_LENGTH_OCTETS + 1);
  localparam int PW1   = POSITION_BITS + 1;

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               tag_r, tag_nxt;
  logic [LOS_W-1:0]         los_r, los_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] size_r, size_nxt;
  logic [POSITION_BITS-1:0] vbl_r, vbl_nxt;
  logic [POSITION_BITS-1:0] vstart_r, vstart_nxt;
  logic [VALUE_BITS-1:0]    vacc_r, vacc_nxt;

  // view of the state once a start beat has cleared it
  phase_t                   ph_e;
  logic [POSITION_BITS-1:0] pos_e, size_e, pos_inc, remaining;
  logic [7:0]               tag_e, b;
  logic [6:0]               n;
  logic [PW1-1:0]           len_end;
  logic                     tag_room, tag_multi, tag_trunc;
  logic                     len_bad, len_over, lx_last, val_last, emit_more;
  logic [31:0]              lx_acc, hdr_acc;
  logic                     hdr_past, hdr_zero;
  logic [LOS_W-1:0]         los_dec;
  logic [POSITION_BITS-1:0] vbl_dec;
  logic [VALUE_BITS-1:0]    vacc_sh;
  phase_t                   emit_phase, hdr_phase;

  assign b         = in_item.data_byte;
  assign n         = in_item.data_byte[6:0];
  assign ph_e      = in_item.start_of_buffer ? PH_TAG : phase_r;
  assign pos_e     = in_item.start_of_buffer ? '0 : pos_r;
  assign size_e    = in_item.start_of_buffer ? POSITION_BITS'(in_item.buffer_length) : size_r;
  assign tag_e     = in_item.start_of_buffer ? 8'd0 : tag_r;
  assign pos_inc   = pos_e + 1'b1;
  assign remaining = size_e - pos_inc;

  assign tag_room  = pos_e < size_e;
  assign tag_multi = b[4:0] == TAG_HIGH_NUM;
  assign tag_trunc = pos_inc >= size_e;
  assign len_end   = PW1'(pos_inc) + PW1'(n);
  assign len_bad   = (n == 7'd0) || (n > 7'(MAX_LENGTH_OCTETS));
  assign len_over  = len_end > PW1'(size_e);
  assign los_dec   = los_r - 1'b1;
  assign lx_last   = los_dec == '0;
  assign lx_acc    = (acc_r > LEN_SAT_LIMIT) ? LEN_SAT : {acc_r[23:0], b};
  assign hdr_acc   = (ph_e == PH_LENX) ? lx_acc : {24'd0, b};
  assign hdr_past  = hdr_acc > 32'(remaining);
  assign hdr_zero  = hdr_acc == 32'd0;
  assign vbl_dec   = vbl_r - 1'b1;
  assign val_last  = vbl_dec == '0;
  assign vacc_sh   = {vacc_r[VALUE_BITS-9:0], b};
  assign emit_more = pos_inc < size_e;

  assign emit_phase = emit_more ? PH_TAG : PH_IDLE;
  assign hdr_phase  = hdr_past ? PH_ERROR : (hdr_zero ? emit_phase : PH_VALUE);

  // next phase
  always_comb begin
    phase_nxt = ph_e;
    case (ph_e)
      PH_TAG: begin
        if (!tag_room) phase_nxt = PH_IDLE;
        else if (tag_multi || tag_trunc) phase_nxt = PH_ERROR;
        else phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (b[7]) phase_nxt = (len_bad || len_over) ? PH_ERROR : PH_LENX;
        else phase_nxt = hdr_phase;
      end
      PH_LENX:  phase_nxt = lx_last ? hdr_phase : PH_LENX;
      PH_VALUE: phase_nxt = val_last ? emit_phase : PH_VALUE;
      PH_IDLE:  phase_nxt = PH_IDLE;
      PH_ERROR: phase_nxt = PH_ERROR;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and element output
  always_comb begin
    tag_nxt    = tag_e;
    los_nxt    = los_r;
    acc_nxt    = acc_r;
    pos_nxt    = pos_e;
    size_nxt   = size_e;
    vbl_nxt    = vbl_r;
    vstart_nxt = vstart_r;
    vacc_nxt   = vacc_r;
    ev_valid   = 1'b0;
    ev         = '0;
    ev.status  = ST_OK;
    case (ph_e)
      PH_TAG: begin
        if (tag_room) begin
          tag_nxt = b;
          pos_nxt = pos_inc;
          if (tag_multi || tag_trunc) begin
            ev_valid  = 1'b1;
            ev.tag    = b;
            ev.status = tag_multi ? ST_MULTI_TAG : ST_TRUNC;
          end
        end
      end
      PH_LEN, PH_LENX: begin
        pos_nxt = pos_inc;
        if (ph_e == PH_LEN && b[7]) begin
          los_nxt = LOS_W'(n);
          acc_nxt = 32'd0;
          if (len_bad || len_over) begin
            ev_valid  = 1'b1;
            ev.tag    = tag_e;
            ev.status = len_bad ? ST_BAD_LEN : ST_TRUNC;
          end
        end else begin
          acc_nxt = hdr_acc;
          if (ph_e == PH_LENX) los_nxt = los_dec;
          if (ph_e == PH_LEN || lx_last) begin
            if (hdr_past) begin
              ev_valid  = 1'b1;
              ev.tag    = tag_e;
              ev.status = ST_PAST_END;
            end else begin
              vstart_nxt = pos_inc;
              vbl_nxt    = POSITION_BITS'(hdr_acc);
              vacc_nxt   = '0;
              if (hdr_zero) begin
                ev_valid  = 1'b1;
                ev.tag    = tag_e;
                ev.offset = 16'(pos_inc);
                ev.done   = pos_inc == size_e;
              end
            end
          end
        end
      end
      PH_VALUE: begin
        pos_nxt  = pos_inc;
        vbl_nxt  = vbl_dec;
        vacc_nxt = vacc_sh;
        if (val_last) begin
          ev_valid  = 1'b1;
          ev.tag    = tag_e;
          ev.length = 16'(acc_r);
          ev.offset = 16'(vstart_r);
          ev.raw    = VALUE_W'(vacc_sh);
          ev.nbytes = (acc_r <= 32'(VALUE_BITS / 8)) ? NB_W'(acc_r) : '0;
          ev.done   = pos_inc == size_e;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r    <= tag_nxt;
      los_r    <= los_nxt;
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      size_r   <= size_nxt;
      vbl_r    <= vbl_nxt;
      vstart_r <= vstart_nxt;
      vacc_r   <= vacc_nxt;
    end
  end

endmodule

// ----- hw/rtl/btsp_fifo.sv -----
module btsp_fifo
  import btsp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- hw/rtl/btsp_back.sv -----
module btsp_back
  import btsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic ev_valid,
  input  ev_t  ev,
  output logic take,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic               valid_r, valid_nxt;
  out_t               out_r, out_nxt;
  logic [6:0]         nbits;
  logic [6:0]         msb_idx;
  logic [VALUE_W-1:0] uval, ext_mask;
  logic               sign;

  assign take      = !valid_r || out_pop;
  assign out_empty = !valid_r;
  assign out_data  = out_r;

  // sign extension of a value of one to eight bytes
  assign nbits    = {ev.nbytes, 3'b000};
  assign msb_idx  = nbits - 7'd1;
  assign uval     = (ev.nbytes == '0) ? '0 : ev.raw;
  assign ext_mask = {VALUE_W{1'b1}} << nbits;
  assign sign     = (ev.nbytes != '0) && (nbits < 7'(VALUE_W)) && ev.raw[msb_idx[5:0]];

  always_comb begin
    out_nxt                = out_r;
    valid_nxt              = valid_r && !out_pop;
    if (take && ev_valid) begin
      valid_nxt              = 1'b1;
      out_nxt.tag_byte       = ev.tag;
      out_nxt.value_length   = ev.length;
      out_nxt.value_offset   = ev.offset;
      out_nxt.unsigned_value = uval;
      out_nxt.signed_value   = sign ? (uval | ext_mask) : uval;
      out_nxt.parse_status   = ev.status;
      out_nxt.buffer_done    = ev.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ----- hw/rtl/ber_tlv_stream_parser.sv -----
// channel  ports                          beat taken when
// input    in_push, in_full, in_data      in_push && !in_full
// result   out_empty, out_pop, out_data   out_pop && !out_empty
//
// one byte per cycle while in_full is low; a result is queued with the byte
// that finishes its element and then moves on to the output register.
// the two-entry element queue sets in_full: it fills only while out_pop is
// held low, and then input stalls until a result is taken.
// rst_n is synchronous; after reset the parser waits for a start beat.
module ber_tlv_stream_parser
  import btsp_pkg::*;
#(
  parameter int POSITION_BITS     = POSITION_BITS_DEF,
  parameter int MAX_LENGTH_OCTETS = MAX_LEN_OCTETS_DEF,
  parameter int VALUE_BITS        = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic accept;
  logic fr_valid;
  ev_t  fr_ev;
  ev_t  q_ev;
  logic q_empty;
  logic bk_take;

  assign accept = in_push && !in_full;

  btsp_front #(
    .POSITION_BITS    (POSITION_BITS),
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS),
    .VALUE_BITS       (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .ev_valid(fr_valid),
    .ev      (fr_ev)
  );

  btsp_fifo #(
    .WIDTH($bits(ev_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (accept && fr_valid),
    .wdata(fr_ev),
    .pop  (bk_take),
    .rdata(q_ev),
    .full (in_full),
    .empty(q_empty)
  );

  btsp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (!q_empty),
    .ev       (q_ev),
    .take     (bk_take),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // the queue can only fill behind a held result
  assert property (@(posedge clk) disable iff (!rst_n) in_full |-> !out_empty)
    else $error("element queue full with no result waiting");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.parse_status != ST_OK) |->
      (out_data.unsigned_value == '0 && out_data.signed_value == '0 &&
       out_data.value_length == '0 && !out_data.buffer_done))
    else $error("error result carries element data");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before it was taken");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench
  import btsp_pkg::*;
;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned BYTES_TARGET = 650;
  localparam int unsigned POS_MASK     = (1 << POSITION_BITS_DEF) - 1;

  class element_scoreboard;
    phase_t      phase;
    logic [7:0]  tag;
    int unsigned len_octets_left;
    logic [31:0] len_acc;
    int unsigned pos;
    int unsigned buf_size;
    int unsigned val_left;
    int unsigned val_start;
    logic [63:0] val_acc;
    out_t        pending_elements[$];
    int unsigned errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase = PH_IDLE;
      tag = '0;
      len_octets_left = 0;
      len_acc = '0;
      pos = 0;
      buf_size = 0;
      val_left = 0;
      val_start = 0;
      val_acc = '0;
    endfunction

    function out_t error_element(status_t st);
      out_t r;
      r = '0;
      r.tag_byte = tag;
      r.parse_status = st;
      phase = PH_ERROR;
      return r;
    endfunction

    function out_t finished_element();
      out_t r;
      r = '0;
      r.tag_byte = tag;
      r.value_length = len_acc[15:0];
      r.value_offset = val_start[15:0];
      if (len_acc >= 1 && len_acc <= VALUE_BITS_DEF / 8) begin
        r.unsigned_value = val_acc;
        r.signed_value = val_acc;
        // sign-extend from the top bit of the first value byte
        if (len_acc < 8 && val_acc[len_acc * 8 - 1])
          r.signed_value = val_acc | ({64{1'b1}} << (len_acc * 8));
      end
      r.buffer_done = (pos == buf_size);
      phase = (pos < buf_size) ? PH_TAG : PH_IDLE;
      return r;
    endfunction

    function bit close_header(output out_t r);
      int unsigned remaining;
      remaining = (pos <= buf_size) ? buf_size - pos : 0;
      r = '0;
      if (len_acc > remaining) begin
        r = error_element(ST_PAST_END);
        return 1;
      end
      val_start = pos;
      val_left = len_acc;
      val_acc = '0;
      if (len_acc == 0) begin
        r = finished_element();
        return 1;
      end
      phase = PH_VALUE;
      return 0;
    endfunction

    function bit decode_byte(input in_t b, output out_t r);
      int unsigned n;
      r = '0;
      if (b.start_of_buffer) begin
        clear();
        buf_size = 32'(b.buffer_length);
        phase = PH_TAG;
      end
      case (phase)
        PH_TAG: begin
          if (pos >= buf_size) begin
            phase = PH_IDLE;
            return 0;
          end
          tag = b.data_byte;
          pos = (pos + 1) & POS_MASK;
          if (b.data_byte[4:0] == TAG_HIGH_NUM) begin
            r = error_element(ST_MULTI_TAG);
            return 1;
          end
          if (pos >= buf_size) begin
            r = error_element(ST_TRUNC);
            return 1;
          end
          phase = PH_LEN;
          return 0;
        end
        PH_LEN: begin
          pos = (pos + 1) & POS_MASK;
          if (b.data_byte[7]) begin
            n = 32'(b.data_byte[6:0]);
            if (n == 0 || n > MAX_LEN_OCTETS_DEF) begin
              r = error_element(ST_BAD_LEN);
              return 1;
            end
            if (pos + n > buf_size) begin
              r = error_element(ST_TRUNC);
              return 1;
            end
            len_octets_left = n;
            len_acc = '0;
            phase = PH_LENX;
            return 0;
          end
          len_acc = {24'd0, b.data_byte};
          return close_header(r);
        end
        PH_LENX: begin
          if (len_acc > LEN_SAT_LIMIT)
            len_acc = LEN_SAT;
          else
            len_acc = {len_acc[23:0], b.data_byte};
          pos = (pos + 1) & POS_MASK;
          if (len_octets_left > 0)
            len_octets_left--;
          if (len_octets_left == 0)
            return close_header(r);
          return 0;
        end
        PH_VALUE: begin
          val_acc = {val_acc[55:0], b.data_byte};
          pos = (pos + 1) & POS_MASK;
          if (val_left > 0)
            val_left--;
          if (val_left == 0) begin
            r = finished_element();
            return 1;
          end
          return 0;
        end
        default: begin
          return 0;
        end
      endcase
      return 0;
    endfunction

    function void note_beat(in_t b);
      out_t r;
      if (decode_byte(b, r))
        pending_elements.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(out_t got);
      out_t want;
      if (pending_elements.size() == 0) begin
        $error("element with nothing expected: tag %02h status %0d",
               got.tag_byte, got.parse_status);
        errors++;
        return;
      end
      want = pending_elements.pop_front();
      compare_field("tag_byte", 64'(want.tag_byte), 64'(got.tag_byte));
      compare_field("value_length", 64'(want.value_length), 64'(got.value_length));
      compare_field("value_offset", 64'(want.value_offset), 64'(got.value_offset));
      compare_field("signed_value", want.signed_value, got.signed_value);
      compare_field("unsigned_value", want.unsigned_value, got.unsigned_value);
      compare_field("parse_status", 64'(want.parse_status), 64'(got.parse_status));
      compare_field("buffer_done", 64'(want.buffer_done), 64'(got.buffer_done));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t  in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;

  element_scoreboard sb;
  logic [7:0]        frame[$];
  bit                hold_req;
  int unsigned       idle_cycles;
  int unsigned       sent_bytes;

  ber_tlv_stream_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input logic [7:0] d, input logic s, input logic [15:0] len,
                           input bit tight);
    in_t b;
    int unsigned gap;
    b.data_byte = d;
    b.start_of_buffer = s;
    b.buffer_length = len;
    gap = tight ? 0 : pick_gap();
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = b;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_beat(b);
    @(negedge clk);
  endtask

  task automatic fill_frame(output logic [15:0] blen);
    int unsigned nelem, vlen, nlen, r, k;
    logic [7:0]  t;
    frame.delete();
    nelem = $urandom_range(1, 4);
    repeat (nelem) begin
      t = 8'($urandom);
      if (t[4:0] == TAG_HIGH_NUM && $urandom_range(0, 9) != 0)
        t[0] = 1'b0;
      frame.push_back(t);
      r = $urandom_range(0, 99);
      vlen = (r < 10) ? 0 : (r < 70) ? $urandom_range(1, 8) :
             (r < 88) ? $urandom_range(9, 12) : $urandom_range(13, 24);
      if ($urandom_range(0, 3) == 0) begin
        // long form, leading zero octets allowed
        nlen = $urandom_range(1, MAX_LEN_OCTETS_DEF);
        frame.push_back(8'h80 | 8'(nlen));
        for (k = nlen; k > 0; k--)
          frame.push_back(8'(vlen >> (8 * (k - 1))));
      end else begin
        frame.push_back(8'(vlen));
      end
      repeat (vlen) frame.push_back(8'($urandom));
    end
    blen = 16'(frame.size());
    r = $urandom_range(0, 99);
    if (r < 6) begin
      blen = 16'($urandom_range(1, frame.size()));
    end else if (r < 10) begin
      frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
    end else if (r < 13) begin
      blen = 16'(frame.size() + $urandom_range(1, 3));
    end else if (r < 17) begin
      // broken header at the tail
      frame.push_back(8'h04);
      case ($urandom_range(0, 3))
        0: frame.push_back(8'h80);
        1: frame.push_back(8'h80 | 8'($urandom_range(MAX_LEN_OCTETS_DEF + 1, 127)));
        2: begin
          frame.push_back(8'h80 | 8'(MAX_LEN_OCTETS_DEF));
          repeat (MAX_LEN_OCTETS_DEF) frame.push_back(8'($urandom));
        end
        default: frame.push_back(8'h7f);
      endcase
      blen = 16'(frame.size());
    end
  endtask

  task automatic send_frame(input logic [15:0] blen);
    bit tight;
    tight = ($urandom_range(0, 3) == 0);
    foreach (frame[i]) begin
      send_beat(frame[i], i == 0, (i == 0) ? blen : 16'($urandom), tight);
      sent_bytes++;
    end
  endtask

  task automatic directed_beats();
    send_beat(8'h02, 1'b0, 16'hffff, 0);  // before any start
    send_beat(8'h30, 1'b1, 16'h0000, 0);  // empty buffer
    send_beat(8'h02, 1'b1, 16'hffff, 0);
    send_beat(8'h01, 1'b0, 16'h0000, 0);
    send_beat(8'h80, 1'b0, 16'h0000, 0);
    send_beat(8'h3f, 1'b1, 16'd5, 0);     // multi-byte tag
    send_beat(8'h00, 1'b0, 16'h0000, 0);  // ignored after error
    send_beat(8'h04, 1'b1, 16'd1, 0);     // tag with no room for length
    send_beat(8'h05, 1'b1, 16'd4, 0);
    send_beat(8'h00, 1'b0, 16'h0000, 0);  // zero-length element
    send_beat(8'h30, 1'b0, 16'h0000, 0);
    send_beat(8'h80, 1'b0, 16'h0000, 0);  // indefinite form
    send_beat(8'h02, 1'b1, 16'd3, 0);
    send_beat(8'h85, 1'b0, 16'h0000, 0);  // too many length octets
    send_beat(8'h04, 1'b1, 16'd3, 0);
    send_beat(8'h82, 1'b0, 16'h0000, 0);  // length octets run off the end
    send_beat(8'h04, 1'b1, 16'd7, 0);
    send_beat(8'h84, 1'b0, 16'h0000, 0);
    repeat (4) send_beat(8'hff, 1'b0, 16'h0000, 0);
    send_beat(8'h02, 1'b1, 16'd3, 0);
    send_beat(8'h05, 1'b0, 16'h0000, 0);  // short length past the end
    send_beat(8'h02, 1'b1, 16'd3, 0);
    send_beat(8'h01, 1'b0, 16'h0000, 0);
    send_beat(8'hff, 1'b0, 16'h0000, 0);
    send_beat(8'h11, 1'b0, 16'h0000, 0);  // past buffer end
  endtask

  initial begin
    logic [15:0] blen;
    bit          paused;
    int unsigned holds_done;
    in_push = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_req = 1'b0;
    sent_bytes = 0;
    paused = 0;
    holds_done = 0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_beats();

    while (sent_bytes < BYTES_TARGET) begin
      if (holds_done < 2 && sent_bytes >= 300 * holds_done) begin
        hold_req = 1'b1;
        holds_done++;
      end
      if (!paused && sent_bytes >= 450) begin
        // let the parser drain completely before carrying on
        paused = 1;
        in_push = 1'b0;
        while (sb.pending_elements.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 8)
        send_beat(8'($urandom), $urandom_range(0, 3) == 0, 16'($urandom), 0);
      else begin
        fill_frame(blen);
        send_frame(blen);
      end
    end
    in_push = 1'b0;

    while (sb.pending_elements.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // result side: random stalls, stall-free stretches and long hold-offs
  initial begin
    int unsigned stall_left, free_left, hold_len;
    out_pop = 1'b0;
    stall_left = 0;
    free_left = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_pop = 1'b0;
        hold_len = $urandom_range(60, 100);
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_pop = 1'b0;
        stall_left--;
      end else begin
        out_pop = 1'b1;
        if (free_left > 0)
          free_left--;
        else if ($urandom_range(0, 3) == 0)
          stall_left = pick_gap();
        else if ($urandom_range(0, 15) == 0)
          free_left = $urandom_range(20, 80);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_beat(out_data);
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
hw/rtl/btsp_pkg.sv
hw/rtl/btsp_front.sv
hw/rtl/btsp_fifo.sv
hw/rtl/btsp_back.sv
hw/rtl/ber_tlv_stream_parser.sv
bench/testbench.sv
